// File: rtl/core/ypf_pkg.sv
`timescale 1ns / 1ps
package ypf_pkg;

	localparam logic [7:0]  MARK_SHORT = 8'h01;
	localparam logic [7:0]  MARK_LONG  = 8'h02;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_TOP    = 16'h8000;

	// Fixed slot layout of the frame bytes that one item can produce
	localparam int unsigned NUM_SLOTS = 6;
	localparam logic [2:0] SLOT_MARK  = 3'd0;
	localparam logic [2:0] SLOT_NUM   = 3'd1;
	localparam logic [2:0] SLOT_CMP   = 3'd2;
	localparam logic [2:0] SLOT_DATA  = 3'd3;
	localparam logic [2:0] SLOT_CRC_H = 3'd4;
	localparam logic [2:0] SLOT_CRC_L = 3'd5;

	typedef logic [7:0] byte_t;

	// One input item as held in the input register
	typedef struct packed {
		byte_t data_byte;
		logic  first_of_block;
		logic  last_of_block;
		logic  long_block;
		logic  restart_sequence;
		logic  resend_previous;
	} item_t;

	// Bytes of one item plus the range of slots to send
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] slots;
		logic [2:0]                first_idx;
		logic [2:0]                last_idx;
	} frame_t;

	// CRC-16/XMODEM, one byte, MSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input byte_t data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/ypf_ifs.sv
`timescale 1ns / 1ps

// Payload byte channel with framing marks
interface ypf_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_block;
	logic       last_of_block;
	logic       long_block;
	logic       restart_sequence;
	logic       resend_previous;

	modport source (output valid, data_byte, first_of_block, last_of_block, long_block,
		restart_sequence, resend_previous, input ready);
	modport sink (input valid, data_byte, first_of_block, last_of_block, long_block,
		restart_sequence, resend_previous, output ready);
endinterface

// Serial line byte channel
interface ypf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;

	modport source (output valid, out_byte, run_last, input ready);
	modport sink (input valid, out_byte, run_last, output ready);
endinterface

// File: rtl/core/ypf_frame_calc.sv
`timescale 1ns / 1ps
module ypf_frame_calc
	import ypf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  item_t  item,
	input  logic   load,
	output frame_t frame
);

	logic [7:0]  next_number_q;
	logic [7:0]  previous_number_q;
	logic [15:0] running_crc_q;

	logic [7:0]  base_number;
	logic [7:0]  block_number;
	logic [7:0]  next_number_d;
	logic [7:0]  previous_number_d;
	logic [15:0] crc_start;
	logic [15:0] crc_new;

	// Block numbering and CRC for the held item
	always_comb begin
		base_number       = item.restart_sequence ? 8'h00 : next_number_q;
		next_number_d     = next_number_q;
		previous_number_d = previous_number_q;
		block_number      = base_number;
		if (item.first_of_block) begin
			if (item.resend_previous) begin
				block_number  = previous_number_q;
				next_number_d = base_number;
			end else begin
				previous_number_d = base_number;
				next_number_d     = base_number + 8'd1;
			end
		end
		crc_start = item.first_of_block ? 16'h0000 : running_crc_q;
		crc_new   = crc_fold(crc_start, item.data_byte);
	end

	// Frame bytes in fixed slots; the range picks the ones to send
	always_comb begin
		frame.slots             = '0;
		frame.slots[SLOT_MARK]  = item.long_block ? MARK_LONG : MARK_SHORT;
		frame.slots[SLOT_NUM]   = block_number;
		frame.slots[SLOT_CMP]   = ~block_number;
		frame.slots[SLOT_DATA]  = item.data_byte;
		frame.slots[SLOT_CRC_H] = crc_new[15:8];
		frame.slots[SLOT_CRC_L] = crc_new[7:0];
		frame.first_idx         = item.first_of_block ? SLOT_MARK : SLOT_DATA;
		frame.last_idx          = item.last_of_block ? SLOT_CRC_L : SLOT_DATA;
	end

	// Block state advances as the item leaves for the output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_number_q     <= 8'h00;
			previous_number_q <= 8'h00;
			running_crc_q     <= 16'h0000;
		end else if (load) begin
			next_number_q     <= next_number_d;
			previous_number_q <= previous_number_d;
			running_crc_q     <= item.last_of_block ? 16'h0000 : crc_new;
		end
	end

endmodule

// File: rtl/core/ypf_serializer.sv
`timescale 1ns / 1ps
module ypf_serializer
	import ypf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  frame_t     frame,
	input  logic       load,
	output logic       free,
	ypf_byte_if.source line
);

	logic [NUM_SLOTS-1:0][7:0] slots_q;
	logic [2:0]                idx_q;
	logic [2:0]                last_idx_q;
	logic                      busy_q;
	logic                      at_end;

	assign at_end        = idx_q == last_idx_q;
	assign line.valid    = busy_q;
	assign line.out_byte = slots_q[idx_q];
	assign line.run_last = at_end;

	// Buffer can take a new frame when empty or on its final transaction
	assign free = !busy_q || (line.ready && at_end);

	// Control: busy flag and slot pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= SLOT_DATA;
			last_idx_q <= SLOT_DATA;
		end else if (load) begin
			busy_q     <= 1'b1;
			idx_q      <= frame.first_idx;
			last_idx_q <= frame.last_idx;
		end else if (busy_q && line.ready) begin
			if (at_end) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Frame bytes
	always_ff @(posedge clk) begin
		if (load) begin
			slots_q <= frame.slots;
		end
	end

endmodule

// File: rtl/core/ymodem_packet_framer_unit.sv
`timescale 1ns / 1ps
// An accepted item passes the input register, then the frame buffer, to the line.
// An item producing n bytes (1 to 6) holds the output until its last byte is taken;
// plain data bytes flow one per ready cycle, header and CRC bytes stall the input.
// The rate is set by the single output byte port draining the frame buffer.
// Reset (arst_n low, asynchronous) clears block number, CRC and all valid flags.
module ymodem_packet_framer_unit
	import ypf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ypf_item_if.sink   payload,
	ypf_byte_if.source serial
);

	item_t  item_s1;
	logic   valid_s1;
	logic   load;
	logic   free;
	frame_t frame;

	assign load          = valid_s1 && free;
	assign payload.ready = !valid_s1 || load;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (payload.ready) begin
			valid_s1 <= payload.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (payload.valid && payload.ready) begin
			item_s1.data_byte        <= payload.data_byte;
			item_s1.first_of_block   <= payload.first_of_block;
			item_s1.last_of_block    <= payload.last_of_block;
			item_s1.long_block       <= payload.long_block;
			item_s1.restart_sequence <= payload.restart_sequence;
			item_s1.resend_previous  <= payload.resend_previous;
		end
	end

	ypf_frame_calc u_calc (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_s1),
		.load  (load),
		.frame (frame)
	);

	ypf_serializer u_ser (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame),
		.load  (load),
		.free  (free),
		.line  (serial)
	);

endmodule

// File: rtl/core/ypf_checker.sv
`timescale 1ns / 1ps
module ypf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_run_last
);

	// A stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_run_last))
		else $error("output changed while stalled");

	// Input only backs up when a frame is waiting on the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with idle output");

	// A frame continues until its last byte
	a_run_continue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_run_last |=> out_valid)
		else $error("frame broke off before its last byte");

	// Idle output never blocks the input
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked while output idle");

endmodule

bind ymodem_packet_framer_unit ypf_checker u_ypf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (payload.ready),
	.out_valid   (serial.valid),
	.out_ready   (serial.ready),
	.out_byte    (serial.out_byte),
	.out_run_last(serial.run_last)
);
